// File: hdl/nft_pkg.sv
// ----------------------------------------------------------------------------
// nft_pkg: shared constants, types and the sensor table
// Table points in Q16.15, the frequency numerator, and the lane result struct.
// ----------------------------------------------------------------------------
package nft_pkg;

  localparam int unsigned STORED_POINTS = 13;
  localparam int unsigned TABLE_POINTS_DEFAULT = 13;
  localparam int unsigned PT_IDX_W = 6;     // table index, covers TABLE_POINTS up to 64
  localparam int unsigned POINT_W = 20;     // largest point 875560
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned TEMP_W = 7;
  localparam int unsigned DIV_W = 32;       // dividend / quotient width
  localparam int unsigned DVS_W = 17;       // divisor width (count or segment span)
  localparam int unsigned STEP_W = $clog2(DIV_W);

  localparam logic [DIV_W-1:0] FREQ_NUM = 32'd1638400000;  // 50000 in Q16.15
  localparam logic [3:0] DEG_PER_SEG = 4'd10;
  localparam logic [DIV_W-1:0] Q15_MAX = 32'd32767;

  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    logic              valid;
  } nft_res_t;

  // Sensor table, Q16.15, truncated.
  function automatic logic [POINT_W-1:0] ntc_point(input logic [PT_IDX_W-1:0] idx);
    logic [POINT_W-1:0] p;
    unique case (idx)
      6'd0:    p = 20'd196280;
      6'd1:    p = 20'd275906;
      6'd2:    p = 20'd364380;
      6'd3:    p = 20'd454492;
      6'd4:    p = 20'd538378;
      6'd5:    p = 20'd611450;
      6'd6:    p = 20'd671416;
      6'd7:    p = 20'd718929;
      6'd8:    p = 20'd755630;
      6'd9:    p = 20'd783810;
      6'd10:   p = 20'd804782;
      6'd11:   p = 20'd820838;
      6'd12:   p = 20'd875560;
      default: p = 20'd0;
    endcase
    return p;
  endfunction

endpackage

// File: hdl/nft_lane.sv
// ----------------------------------------------------------------------------
// nft_lane: one sensor channel
// Iterative restoring divider shared by the frequency and fraction divides,
// a table search between them, then the temperature interpolation.
// ----------------------------------------------------------------------------
module nft_lane
  import nft_pkg::*;
#(
  parameter int unsigned TABLE_POINTS = TABLE_POINTS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [COUNT_W-1:0] count_i,
  output logic               ready_o,
  output logic               done_o,
  input  logic               take_i,
  output nft_res_t           res_o
);

  localparam int unsigned NPTS = (TABLE_POINTS < STORED_POINTS) ? TABLE_POINTS : STORED_POINTS;
  localparam int unsigned IDX_W = (NPTS > 1) ? $clog2(NPTS) : 1;

  typedef enum logic [5:0] {
    L_IDLE   = 6'b000001,
    L_DIV_F  = 6'b000010,
    L_SEARCH = 6'b000100,
    L_DIV_Q  = 6'b001000,
    L_FINISH = 6'b010000,
    L_DONE   = 6'b100000
  } lane_state_e;

  lane_state_e        state_q, state_d;
  logic [DIV_W-1:0]   dvd_q, dvd_d;
  logic [DIV_W-1:0]   quo_q, quo_d;
  logic [DVS_W-1:0]   rem_q, rem_d;
  logic [DVS_W-1:0]   dvs_q, dvs_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  nft_res_t           res_q, res_d;

  // divider step
  logic [DVS_W:0]     sh;
  logic               ge;
  logic [DVS_W:0]     diff;

  // search
  logic [IDX_W-1:0]   sel;
  logic [POINT_W-1:0] lo_pt, hi_pt, first_pt, last_pt, off;
  logic               in_range;

  // interpolation
  logic [14:0]        qs;
  logic [18:0]        prod;
  logic [7:0]         seg, tsum;

  always_comb begin
    sh   = {rem_q, dvd_q[DIV_W-1]};
    ge   = (sh >= {1'b0, dvs_q});
    diff = sh - {1'b0, dvs_q};
  end

  always_comb begin
    first_pt = ntc_point('0);
    last_pt  = ntc_point(PT_IDX_W'(NPTS - 1));
    in_range = (quo_q >= DIV_W'(first_pt)) && (quo_q <= DIV_W'(last_pt));
    sel = IDX_W'(NPTS - 1);
    for (int i = NPTS - 1; i >= 1; i--) begin
      if (quo_q <= DIV_W'(ntc_point(PT_IDX_W'(i)))) begin
        sel = IDX_W'(i);
      end
    end
    hi_pt = ntc_point(PT_IDX_W'(sel));
    lo_pt = ntc_point(PT_IDX_W'(sel) - PT_IDX_W'(1));
    off   = quo_q[POINT_W-1:0] - lo_pt;
  end

  always_comb begin
    qs   = (quo_q > Q15_MAX) ? Q15_MAX[14:0] : quo_q[14:0];
    prod = 19'(qs) * 19'(DEG_PER_SEG);
    seg  = 8'(idx_q) - 8'd1;
    tsum = 8'(seg * 8'(DEG_PER_SEG)) + {4'b0, prod[18:15]};
  end

  always_comb begin
    state_d = state_q;
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    step_d  = step_q;
    idx_d   = idx_q;
    res_d   = res_q;
    unique case (state_q)
      L_IDLE: begin
        if (start_i) begin
          dvd_d  = FREQ_NUM;
          dvs_d  = {1'b0, count_i};
          rem_d  = '0;
          step_d = '0;
          res_d  = '0;
          state_d = (count_i == '0) ? L_DONE : L_DIV_F;
        end
      end
      L_DIV_F, L_DIV_Q: begin
        rem_d  = ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
        quo_d  = {quo_q[DIV_W-2:0], ge};
        dvd_d  = {dvd_q[DIV_W-2:0], 1'b0};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_W - 1)) begin
          state_d = (state_q == L_DIV_F) ? L_SEARCH : L_FINISH;
        end
      end
      L_SEARCH: begin
        if (!in_range) begin
          res_d   = '0;
          state_d = L_DONE;
        end else if (quo_q == DIV_W'(first_pt)) begin
          res_d   = '{temp: '0, valid: 1'b1};
          state_d = L_DONE;
        end else begin
          // offset <= span < 2^17, so the Q15 shift fits the dividend
          dvd_d   = {off[DVS_W-1:0], 15'b0};
          dvs_d   = DVS_W'(hi_pt - lo_pt);
          rem_d   = '0;
          step_d  = '0;
          idx_d   = sel;
          state_d = L_DIV_Q;
        end
      end
      L_FINISH: begin
        res_d   = '{temp: tsum[TEMP_W-1:0], valid: 1'b1};
        state_d = L_DONE;
      end
      L_DONE: begin
        if (take_i) state_d = L_IDLE;
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    step_q <= step_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
  end

  assign ready_o = (state_q == L_IDLE);
  assign done_o  = (state_q == L_DONE);
  assign res_o   = res_q;

endmodule

// File: hdl/ntc_frequency_to_temperature_core.sv
// ----------------------------------------------------------------------------
// ntc_frequency_to_temperature_core: dual NTC oscillator period to temperature
// Two channel lanes in parallel, merged into one registered result.
// ----------------------------------------------------------------------------
// Each request carries two capture periods (high- and low-voltage sensor).
// Both lanes convert their count independently: frequency = 1638400000/count
// in Q16.15 by a 32-step restoring divide, a table search for the
// segment, then a second 32-step divide for the Q15 fraction and the
// interpolation temp = 10*(seg-1) + (10*frac >> 15). A zero count or a
// frequency off the table yields valid=0, temp=0. A reading uses the search,
// the finish step and both divides of the bit-serial divider in its lane
// before the hand-off; a zero count or off-table reading ends sooner. A new
// request is taken as soon as both lanes are idle, while the previous result
// may still wait in the output register.
// ----------------------------------------------------------------------------
module ntc_frequency_to_temperature_core
  import nft_pkg::*;
#(
  parameter int unsigned TABLE_POINTS = TABLE_POINTS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] hv_capture_count, [31:16] lv_capture_count
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [6:0] hv_temperature, [7] hv_valid,
                                      // [14:8] lv_temperature, [15] lv_valid
);

  logic     in_acc;
  logic     hv_ready, lv_ready, hv_done, lv_done;
  logic     load;
  nft_res_t hv_res, lv_res;
  logic     out_vld_q;
  nft_res_t out_hv_q, out_lv_q;

  assign s_axis_tready = hv_ready & lv_ready;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  nft_lane #(.TABLE_POINTS(TABLE_POINTS)) u_hv_lane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .count_i (s_axis_tdata[15:0]),
    .ready_o (hv_ready),
    .done_o  (hv_done),
    .take_i  (load),
    .res_o   (hv_res)
  );

  nft_lane #(.TABLE_POINTS(TABLE_POINTS)) u_lv_lane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .count_i (s_axis_tdata[31:16]),
    .ready_o (lv_ready),
    .done_o  (lv_done),
    .take_i  (load),
    .res_o   (lv_res)
  );

  // merge: both lanes finished and output slot free or draining
  assign load = hv_done & lv_done & (~out_vld_q | m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_hv_q <= hv_res;
      out_lv_q <= lv_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_lv_q.valid, out_lv_q.temp, out_hv_q.valid, out_hv_q.temp};

  // an invalid reading always reports zero temperature
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((out_hv_q.valid || out_hv_q.temp == '0) &&
                   (out_lv_q.valid || out_lv_q.temp == '0)))
    else $error("invalid reading with nonzero temperature");

  // temperature stays within the twelve table segments
  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_hv_q.temp <= 7'd119 && out_lv_q.temp <= 7'd119))
    else $error("temperature beyond table range");

  // lanes leave idle right after a request is taken
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input ready while lanes busy");

  // a lane result is only moved when both lanes have finished
  a_merge_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (hv_done && lv_done && !hv_ready && !lv_ready))
    else $error("merge without both lane results");

endmodule

// File: sim/ntc_reading_checker.sv
// ----------------------------------------------------------------------------
// ntc_reading_checker: scoreboard for the NTC frequency-to-temperature core
// Predicts both lane readings of every accepted request and compares each
// accepted result with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module ntc_reading_checker
  import nft_pkg::*;
#(
  parameter int unsigned TABLE_POINTS = TABLE_POINTS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned in_table_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POINTS_USED = (TABLE_POINTS < 13) ? TABLE_POINTS : 13;

  // sensor curve, Q16.15, truncated
  localparam logic [31:0] SENSOR_FREQ [13] = '{
    32'd196280, 32'd275906, 32'd364380, 32'd454492, 32'd538378, 32'd611450, 32'd671416,
    32'd718929, 32'd755630, 32'd783810, 32'd804782, 32'd820838, 32'd875560
  };

  typedef struct {
    logic [15:0] hv_count;
    logic [15:0] lv_count;
    nft_res_t    hv;
    nft_res_t    lv;
  } reading_pair_t;

  reading_pair_t expected_readings_q[$];
  int unsigned   mismatch_total = 0;
  int unsigned   checked_total = 0;
  int unsigned   in_table_total = 0;

  function automatic nft_res_t predict_temperature(input logic [15:0] count);
    nft_res_t    r;
    logic [31:0] freq;
    logic [31:0] lo;
    logic [31:0] span;
    logic [63:0] frac;
    int unsigned deg;
    r = '0;
    if (count == 16'd0) return r;
    freq = FREQ_NUM / {16'd0, count};
    if (freq < SENSOR_FREQ[0] || freq > SENSOR_FREQ[POINTS_USED-1]) return r;
    r.valid = 1'b1;
    if (freq == SENSOR_FREQ[0]) return r;
    for (int seg = 1; seg < POINTS_USED; seg++) begin
      if (freq <= SENSOR_FREQ[seg]) begin
        lo = SENSOR_FREQ[seg-1];
        span = SENSOR_FREQ[seg] - lo;
        frac = (span != 0) ? (({32'd0, freq - lo} << 15) / {32'd0, span}) : 64'd32767;
        if (frac > 64'd32767) frac = 64'd32767;
        deg = 10 * (seg - 1) + int'((64'd10 * frac) >> 15);
        r.temp = deg[TEMP_W-1:0];
        return r;
      end
    end
    return r;
  endfunction

  task automatic check_lane(input string lane, input logic [15:0] count, input nft_res_t want,
                            input logic [6:0] temp, input logic valid);
    if (temp !== want.temp || valid !== want.valid) begin
      mismatch_total++;
      $display("%0t: %s lane, count %0d: expected temp %0d valid %0b, got temp %0d valid %0b",
               $time, lane, count, want.temp, want.valid, temp, valid);
    end
  endtask

  always @(posedge clk_i) begin
    reading_pair_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        want.hv_count = s_axis_tdata[15:0];
        want.lv_count = s_axis_tdata[31:16];
        want.hv = predict_temperature(want.hv_count);
        want.lv = predict_temperature(want.lv_count);
        expected_readings_q.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_readings_q.size() == 0) begin
          mismatch_total++;
          $display("%0t: expected no result, got 0x%04h", $time, m_axis_tdata);
        end else begin
          want = expected_readings_q.pop_front();
          check_lane("hv", want.hv_count, want.hv, m_axis_tdata[6:0], m_axis_tdata[7]);
          check_lane("lv", want.lv_count, want.lv, m_axis_tdata[14:8], m_axis_tdata[15]);
          checked_total++;
          in_table_total += int'(want.hv.valid) + int'(want.lv.valid);
        end
      end
    end
    mismatches_o <= mismatch_total;
    pending_o <= expected_readings_q.size();
    checked_o <= checked_total;
    in_table_o <= in_table_total;
  end

endmodule

// File: sim/tb_ntc_frequency_to_temperature_core.sv
// ----------------------------------------------------------------------------
// tb_ntc_frequency_to_temperature_core: testbench for the NTC conversion core
// Drives dual capture-count requests (directed corners, then bursty random
// traffic) against a stalling result sink; the checker scores every result.
// ----------------------------------------------------------------------------
module tb_ntc_frequency_to_temperature_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS     = 600;
  localparam int unsigned CYCLE_LIMIT      = 500000;  // far above the slowest legal run
  localparam int unsigned SETTLE_CYCLES    = 100;
  localparam int unsigned LONG_HOLD_CYCLES = 400;

  // result sink stall patterns
  typedef enum int unsigned {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_pattern_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [15:0] hv_capture_count, [31:16] lv_capture_count
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [6:0] hv_temperature, [7] hv_valid,
                               // [14:8] lv_temperature, [15] lv_valid

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned in_table;
  int unsigned sent_cnt = 0;
  logic        long_hold_req;

  // Counts whose frequency lands on (or just past) each table point; hitting
  // these and their neighbors exercises segment edges and the saturated fraction.
  int unsigned point_count [13] = '{
    8347, 5938, 4496, 3604, 3043, 2679, 2440, 2278, 2168, 2090, 2035, 1996, 1871
  };

  always #1 clk_i = ~clk_i;

  ntc_frequency_to_temperature_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  ntc_reading_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .in_table_o   (in_table)
  );

  // Offer one request and hold it until the core takes it. Valid stays high
  // on return so back-to-back requests follow without a gap.
  task automatic send_reading(input logic [15:0] hv, input logic [15:0] lv);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {lv, hv};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_cnt++;
  endtask

  // Sender gap; cycles must be at least one.
  task automatic idle_sender(input int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= $urandom;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stop sending until every outstanding request has produced its result.
  // The first edge lets the checker's count catch up with the last request.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Mostly in-table counts, with zeros, full-range noise and table-point hits.
  function automatic logic [15:0] pick_count();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return 16'd0;
    if (sel < 20) return 16'($urandom);
    if (sel < 32) return 16'(point_count[$urandom_range(0, 12)] + $urandom_range(0, 4) - 2);
    return 16'($urandom_range(1800, 8500));
  endfunction

  // Result sink: random stall patterns, plus one long hold-off so the core
  // backs up and drops its input ready while requests keep coming.
  initial begin
    int unsigned hold_left;
    int unsigned pattern_left;
    rx_pattern_e pattern;
    bit          hold_taken;
    logic        ready;
    hold_left = 0;
    pattern_left = 0;
    pattern = RX_ALWAYS;
    hold_taken = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (pattern_left == 0) begin
        pattern = rx_pattern_e'($urandom_range(0, 3));
        pattern_left = $urandom_range(20, 200);
      end
      pattern_left--;
      if (hold_left != 0) begin
        hold_left--;
        ready = 1'b0;
      end else begin
        case (pattern)
          RX_ALWAYS:   ready = 1'b1;
          RX_COIN:     ready = 1'($urandom_range(0, 1));
          RX_SPARSE:   ready = ($urandom_range(0, 3) == 0);
          default:     ready = ((pattern_left % 16) < 12);
        endcase
      end
      m_axis_tready <= ready;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results still outstanding", CYCLE_LIMIT, pending);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned directed_cnt;
    int unsigned burst;
    bit          mid_drain_done;
    mid_drain_done = 1'b0;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    long_hold_req <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: no signal, extreme counts, off-table on both sides,
    // every table point and its neighbor, alternating bit patterns.
    send_reading(16'd0, 16'd0);
    send_reading(16'd1, 16'hFFFF);
    send_reading(16'hFFFF, 16'd1);
    send_reading(16'd0, 16'd5000);
    send_reading(16'd1870, 16'd8348);
    for (int i = 0; i < 13; i++)
      send_reading(16'(point_count[i]), 16'(point_count[i] + 1));
    send_reading(16'hAAAA, 16'h5555);
    send_reading(16'd8346, 16'd1872);
    directed_cnt = sent_cnt;
    drain_results();

    // Random traffic in bursts; the sink's long hold starts right away.
    long_hold_req <= 1'b1;
    while (sent_cnt < directed_cnt + RANDOM_ITEMS) begin
      burst = $urandom_range(1, 10);
      repeat (burst) send_reading(pick_count(), pick_count());
      if (!mid_drain_done && sent_cnt >= directed_cnt + RANDOM_ITEMS / 2) begin
        mid_drain_done = 1'b1;
        drain_results();
      end else if ($urandom_range(0, 3) != 0) begin
        idle_sender($urandom_range(1, 15));
      end
    end
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d requests (%0d directed, %0d random), %0d results checked",
             sent_cnt, directed_cnt, sent_cnt - directed_cnt, checked);
    $display("%0d of %0d lane readings in table, %0d mismatches, %0d left outstanding",
             in_table, 2 * checked, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
